@@ sv/assert_macros.svh @@
// Assertion macros for the mask blitter; clk and arst_n come from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define M2X_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("m2xblit: property violated");
`define M2X_NEVER(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) \
	else $error("m2xblit: forbidden condition seen");
`else
`define M2X_ASSERT(lbl, prop)
`define M2X_NEVER(lbl, prop)
`endif
`endif

@@ sv/m2xblit_pkg.sv @@
// Shared constants, register indexes and types of the mask blitter.
package m2xblit_pkg;

	localparam int MAX_SOURCE_WIDTH = 2048;
	localparam int MAX_DEST_WIDTH   = 4096;

	localparam int LS_DEPTH = MAX_SOURCE_WIDTH / 8;
	localparam int LS_AW    = $clog2(LS_DEPTH);

	// byte pitch of a 12-bit source width
	localparam int SPW    = 10;
	localparam int HALF_W = 13;
	localparam int ADDR_W = 23;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POS_X       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Y       = 3'd5;

	typedef struct packed {
		logic [HALF_W-1:0] half;
		logic              upper;
		logic [3:0]        nib;
	} lane_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [3:0]        mask;
		lane_t [3:0]       lane;
	} group_t;

	typedef struct packed {
		logic   valid;
		group_t grp;
	} push_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           empty;
	} q_stat_t;

endpackage

@@ sv/m2xblit_ifs.sv @@
// Handshake channels of the mask blitter: source bytes, nibble writes, register writes.
interface m2xblit_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] mask_byte;
	logic       image_start;
	modport source(output valid, mask_byte, image_start, input ready);
	modport sink(input valid, mask_byte, image_start, output ready);
endinterface

interface m2xblit_out_if;
	logic                              valid;
	logic                              ready;
	logic [m2xblit_pkg::ADDR_W-1:0]    dest_address;
	logic [3:0]                        nibble_value;
	logic                              upper_half;
	logic                              last_of_run;
	modport source(output valid, dest_address, nibble_value, upper_half, last_of_run,
		input ready);
	modport sink(input valid, dest_address, nibble_value, upper_half, last_of_run,
		output ready);
endinterface

interface m2xblit_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [m2xblit_pkg::CFG_IDX_W-1:0]    index;
	logic [m2xblit_pkg::CFG_DATA_W-1:0]   data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ sv/mask_2x_to_packed_nibble_blit.sv @@
// Top level of the 2x mask to packed nibble blitter.
//
//   channel | role         | words carried
//   --------+--------------+----------------------------------------------------
//   src     | sink         | mask_byte, image_start: one source byte per word
//   dst     | source       | dest_address, nibble_value, upper_half, last_of_run
//   cfg     | sink         | index, data: register writes, always ready
//
// A byte is taken when src.valid and src.ready are high; its nibble writes pass stage 1,
// stage 2, the queue and the output register, then leave one per cycle while dst is ready.
// Even-row or fully clipped bytes give no word; a fully visible odd-row byte gives four words.
// src stalls while the group queue and the two front stages hold four groups.
// Reset clears the raster position and registers at once; the line store has no clearing.
`include "assert_macros.svh"

module mask_2x_to_packed_nibble_blit (
	input  logic           clk,
	input  logic           arst_n,
	m2xblit_in_if.sink     src,
	m2xblit_out_if.source  dst,
	m2xblit_cfg_if.sink    cfg
);

	m2xblit_pkg::push_t   q_push;
	m2xblit_pkg::q_stat_t q_stat;
	m2xblit_pkg::group_t  head;
	logic                 q_pop;

	m2xblit_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.cfg    (cfg),
		.q_stat (q_stat),
		.q_push (q_push)
	);

	m2xblit_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_pop  (q_pop),
		.head   (head),
		.q_stat (q_stat)
	);

	m2xblit_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.dst    (dst)
	);

	`M2X_ASSERT(a_queue_bound, q_stat.count <= m2xblit_pkg::QCW'(m2xblit_pkg::QDEPTH))
	`M2X_NEVER(a_pop_empty, q_pop && q_stat.empty)
	`M2X_NEVER(a_push_full, q_push.valid && (q_stat.count == m2xblit_pkg::QCW'(m2xblit_pkg::QDEPTH)))

endmodule

@@ sv/m2xblit_front.sv @@
// Front end: registers, raster tracking, line store, 2x2 gather and clipping into nibble groups.
module m2xblit_front (
	input  logic                 clk,
	input  logic                 arst_n,
	m2xblit_in_if.sink           src,
	m2xblit_cfg_if.sink          cfg,
	input  m2xblit_pkg::q_stat_t q_stat,
	output m2xblit_pkg::push_t   q_push
);

	logic [12:0] dest_width_q, dest_height_q, src_height_q;
	logic [11:0] src_width_q;
	logic [13:0] pos_x_q, pos_y_q;

	logic [m2xblit_pkg::LS_AW-1:0] byte_column_q;
	logic [12:0]                   source_row_q;

	logic [7:0] line_store [m2xblit_pkg::LS_DEPTH];

	logic [11:0] sw;
	logic [12:0] dw;
	logic [m2xblit_pkg::SPW-1:0] spitch;
	logic [12:0] dpitch;

	logic                          acc;
	logic [m2xblit_pkg::LS_AW-1:0] col0, col1, nxt_col;
	logic [12:0]                   row0, row1, nxt_row;
	logic                          skip0, wrap, skip1, go, end_row;
	logic [m2xblit_pkg::SPW-1:0]   col2;
	logic [3:0]                    occ;

	// stage 1: odd-row byte with its line store partner
	logic                          v_s1;
	logic [m2xblit_pkg::LS_AW-1:0] col_s1;
	logic [12:0]                   row_s1;
	logic [7:0]                    cur_s1, top_s1;

	logic [14:0]        dy;
	logic               row_ok;
	logic signed [15:0] dx [4];
	logic [3:0]         lane_ok;
	m2xblit_pkg::lane_t [3:0] lanes;

	// stage 2: clipped group waiting for its row base
	logic                     v_s2;
	logic [12:0]              dy_s2;
	logic [3:0]               mask_s2;
	m2xblit_pkg::lane_t [3:0] lanes_s2;
	logic [25:0]              prod;

	function automatic logic [m2xblit_pkg::SPW-1:0] SPW_CAST(input logic [12:0] v);
		logic [12:0] s;
		s = v >> 3;
		return s[m2xblit_pkg::SPW-1:0];
	endfunction

	assign cfg.ready = 1'b1;

	always_comb begin
		sw = (14'(src_width_q) > 14'(m2xblit_pkg::MAX_SOURCE_WIDTH))
			? 12'(m2xblit_pkg::MAX_SOURCE_WIDTH) : src_width_q;
		dw = (15'(dest_width_q) > 15'(m2xblit_pkg::MAX_DEST_WIDTH))
			? 13'(m2xblit_pkg::MAX_DEST_WIDTH) : dest_width_q;
		spitch = SPW_CAST(13'(sw) + 13'd7);
		dpitch = 13'(((14'(dw) + 14'd7) >> 3) << 2);
	end

	assign occ = 4'(q_stat.count) + 4'(v_s1) + 4'(v_s2);
	assign src.ready = (occ < 4'(m2xblit_pkg::QDEPTH));
	assign acc = src.valid && src.ready;

	// raster position of this byte and of the next one
	always_comb begin
		col0    = src.image_start ? '0 : byte_column_q;
		row0    = src.image_start ? '0 : source_row_q;
		skip0   = (spitch == '0) || (row0 >= src_height_q);
		wrap    = (m2xblit_pkg::SPW'(col0) >= spitch);
		col1    = wrap ? '0 : col0;
		row1    = wrap ? row0 + 13'd1 : row0;
		skip1   = wrap && (row1 >= src_height_q);
		go      = !skip0 && !skip1;
		col2    = m2xblit_pkg::SPW'(col1) + m2xblit_pkg::SPW'(1);
		end_row = (col2 >= spitch);
		priority if (skip0) begin
			nxt_col = col0;
			nxt_row = row0;
		end else if (skip1) begin
			nxt_col = col1;
			nxt_row = row1;
		end else if (end_row) begin
			nxt_col = '0;
			nxt_row = row1 + 13'd1;
		end else begin
			nxt_col = col2[m2xblit_pkg::LS_AW-1:0];
			nxt_row = row1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_width_q  <= '0;
			dest_height_q <= '0;
			src_width_q   <= '0;
			src_height_q  <= '0;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			byte_column_q <= '0;
			source_row_q  <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					m2xblit_pkg::REG_DEST_WIDTH:  dest_width_q  <= cfg.data[12:0];
					m2xblit_pkg::REG_DEST_HEIGHT: dest_height_q <= cfg.data[12:0];
					m2xblit_pkg::REG_SRC_WIDTH:   src_width_q   <= cfg.data[11:0];
					m2xblit_pkg::REG_SRC_HEIGHT:  src_height_q  <= cfg.data[12:0];
					m2xblit_pkg::REG_POS_X:       pos_x_q       <= cfg.data[13:0];
					m2xblit_pkg::REG_POS_Y:       pos_y_q       <= cfg.data[13:0];
					default: ;
				endcase
			end
			if (acc) begin
				byte_column_q <= nxt_col;
				source_row_q  <= nxt_row;
			end
			v_s1 <= acc && go && row1[0];
			v_s2 <= v_s1 && (lane_ok != 4'b0000);
		end
	end

	// even rows fill the line store, odd rows read it back
	always_ff @(posedge clk) begin
		if (acc && go && !row1[0]) begin
			line_store[col1] <= src.mask_byte;
		end
		if (acc && go && row1[0]) begin
			top_s1 <= line_store[col1];
			col_s1 <= col1;
			row_s1 <= row1;
			cur_s1 <= src.mask_byte;
		end
	end

	// destination row, clip and pack the four 2x2 blocks
	always_comb begin
		dy     = {pos_y_q[13], pos_y_q} + {3'b000, row_s1[12:1]};
		row_ok = (row_s1 < {src_height_q[12:1], 1'b0}) && !dy[14] &&
			(dy[13:0] < {1'b0, dest_height_q});
		for (int k = 0; k < 4; k++) begin
			dx[k] = {{2{pos_x_q[13]}}, pos_x_q} + 16'({col_s1, 2'(k)});
			lane_ok[k] = row_ok &&
				(16'({col_s1, 2'(k)}) < 16'(sw[11:1])) &&
				!dx[k][15] && (dx[k] < $signed(16'(dw)));
			lanes[k].half  = dx[k][m2xblit_pkg::HALF_W:1];
			lanes[k].upper = !dx[k][0];
			lanes[k].nib   = {top_s1[7-2*k -: 2], cur_s1[7-2*k -: 2]};
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			dy_s2    <= dy[12:0];
			mask_s2  <= lane_ok;
			lanes_s2 <= lanes;
		end
	end

	assign prod = dy_s2 * dpitch;

	always_comb begin
		q_push.valid    = v_s2;
		q_push.grp.base = prod[m2xblit_pkg::ADDR_W-1:0];
		q_push.grp.mask = mask_s2;
		q_push.grp.lane = lanes_s2;
	end

endmodule

@@ sv/m2xblit_queue.sv @@
// Short queue of nibble groups between the front and back ends.
module m2xblit_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  m2xblit_pkg::push_t   q_push,
	input  logic                 q_pop,
	output m2xblit_pkg::group_t  head,
	output m2xblit_pkg::q_stat_t q_stat
);

	m2xblit_pkg::group_t            entry_q [m2xblit_pkg::QDEPTH];
	logic [m2xblit_pkg::QAW-1:0]    wr_q, rd_q;
	logic [m2xblit_pkg::QCW-1:0]    count_q;

	function automatic logic [m2xblit_pkg::QAW-1:0] bump(input logic [m2xblit_pkg::QAW-1:0] p);
		return (p == m2xblit_pkg::QAW'(m2xblit_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (q_push.valid) begin
				wr_q <= bump(wr_q);
			end
			if (q_pop) begin
				rd_q <= bump(rd_q);
			end
			unique case ({q_push.valid, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_push.valid) begin
			entry_q[wr_q] <= q_push.grp;
		end
	end

	assign head         = entry_q[rd_q];
	assign q_stat.count = count_q;
	assign q_stat.empty = (count_q == '0);

endmodule

@@ sv/m2xblit_back.sv @@
// Back end: walks the live lanes of the head group and drives the nibble write channel.
module m2xblit_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  m2xblit_pkg::group_t  head,
	input  m2xblit_pkg::q_stat_t q_stat,
	output logic                 q_pop,
	m2xblit_out_if.source        dst
);

	logic [3:0] done_q;
	logic [3:0] avail, sel_oh, rest;
	logic [1:0] sel;
	logic       last, load, emit;

	logic                           out_valid_q;
	logic [m2xblit_pkg::ADDR_W-1:0] addr_q;
	logic [3:0]                     nib_q;
	logic                           upper_q, last_q;

	always_comb begin
		avail = head.mask & ~done_q;
		priority if (avail[0]) begin
			sel = 2'd0;
		end else if (avail[1]) begin
			sel = 2'd1;
		end else if (avail[2]) begin
			sel = 2'd2;
		end else begin
			sel = 2'd3;
		end
		sel_oh = 4'b0001 << sel;
		rest   = avail & ~sel_oh;
		last   = (rest == 4'b0000);
		load   = !out_valid_q || dst.ready;
		emit   = load && !q_stat.empty;
		q_pop  = emit && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				// drop the lane just sent; clear on the group's last lane
				done_q <= last ? 4'b0000 : (done_q | sel_oh);
			end
			if (load) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q  <= head.base + m2xblit_pkg::ADDR_W'(head.lane[sel].half);
			nib_q   <= head.lane[sel].nib;
			upper_q <= head.lane[sel].upper;
			last_q  <= last;
		end
	end

	assign dst.valid        = out_valid_q;
	assign dst.dest_address = addr_q;
	assign dst.nibble_value = nib_q;
	assign dst.upper_half   = upper_q;
	assign dst.last_of_run  = last_q;

endmodule

@@ dv/m2xblit_nibble_checker.sv @@
// Checker for the mask blitter: predicts nibble writes per source byte and compares them.
`timescale 1ns / 100ps

module m2xblit_nibble_checker (
	input  logic   clk,
	input  logic   arst_n,
	m2xblit_in_if  src,
	m2xblit_out_if dst,
	m2xblit_cfg_if cfg,
	output int     mismatches,
	output int     writes_due
);

	typedef struct packed {
		logic [m2xblit_pkg::ADDR_W-1:0] addr;
		logic [3:0]                     nib;
		logic                           upper;
		logic                           last;
	} nib_write_t;

	nib_write_t pending_writes[$];
	logic [7:0] even_row[m2xblit_pkg::LS_DEPTH];
	int         byte_col, src_row;
	int         dest_w, dest_h, src_w, src_h, off_x, off_y;

	function automatic void apply_reg(logic [m2xblit_pkg::CFG_IDX_W-1:0] idx,
			logic [m2xblit_pkg::CFG_DATA_W-1:0] d);
		unique case (idx)
			m2xblit_pkg::REG_DEST_WIDTH:  dest_w = int'(d[12:0]);
			m2xblit_pkg::REG_DEST_HEIGHT: dest_h = int'(d[12:0]);
			m2xblit_pkg::REG_SRC_WIDTH:   src_w  = int'(d[11:0]);
			m2xblit_pkg::REG_SRC_HEIGHT:  src_h  = int'(d[12:0]);
			m2xblit_pkg::REG_POS_X:       off_x  = int'($signed(d));
			m2xblit_pkg::REG_POS_Y:       off_y  = int'($signed(d));
			default: ;
		endcase
	endfunction

	// Turn one source byte into the nibble writes it causes.
	function automatic void blit_byte(logic [7:0] cur, logic first);
		int         sw, dw, spitch, dpitch, dy, dx, col, acc, n;
		logic [7:0] top;
		nib_write_t batch[4];
		sw = (src_w > m2xblit_pkg::MAX_SOURCE_WIDTH) ? m2xblit_pkg::MAX_SOURCE_WIDTH : src_w;
		dw = (dest_w > m2xblit_pkg::MAX_DEST_WIDTH) ? m2xblit_pkg::MAX_DEST_WIDTH : dest_w;
		spitch = (sw + 7) / 8;
		dpitch = ((dw * 4 + 31) / 32) * 4;
		n = 0;
		if (first) begin
			byte_col = 0;
			src_row  = 0;
		end
		if (spitch == 0 || src_row >= src_h)
			return;
		// a pitch shrunk under the current column ends the row
		if (byte_col >= spitch) begin
			byte_col = 0;
			src_row++;
			if (src_row >= src_h)
				return;
		end
		if (src_row % 2 == 0) begin
			if (byte_col < m2xblit_pkg::LS_DEPTH)
				even_row[byte_col] = cur;
		end else begin
			dy  = off_y + src_row / 2;
			top = (byte_col < m2xblit_pkg::LS_DEPTH) ? even_row[byte_col] : 8'h00;
			if (src_row < (src_h & ~1) && dy >= 0 && dy < dest_h) begin
				for (int k = 0; k < 4; k++) begin
					col = byte_col * 4 + k;
					dx  = off_x + col;
					if (col >= sw / 2 || dx < 0 || dx >= dw)
						continue;
					acc = dy * dpitch + dx / 2;
					batch[n].addr  = acc[m2xblit_pkg::ADDR_W-1:0];
					batch[n].nib   = {top[7-2*k -: 2], cur[7-2*k -: 2]};
					batch[n].upper = ~dx[0];
					batch[n].last  = 1'b0;
					n++;
				end
				for (int i = 0; i < n; i++) begin
					if (i == n - 1)
						batch[i].last = 1'b1;
					pending_writes.push_back(batch[i]);
				end
			end
		end
		byte_col++;
		if (byte_col >= spitch) begin
			byte_col = 0;
			src_row++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		nib_write_t want;
		if (!arst_n) begin
			pending_writes.delete();
			byte_col   = 0;
			src_row    = 0;
			dest_w     = 0;
			dest_h     = 0;
			src_w      = 0;
			src_h      = 0;
			off_x      = 0;
			off_y      = 0;
			mismatches = 0;
			writes_due = 0;
		end else begin
			if (dst.valid && dst.ready) begin
				if (pending_writes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected word addr=%h nib=%h upper=%b last=%b",
							$realtime, dst.dest_address, dst.nibble_value,
							dst.upper_half, dst.last_of_run);
				end else begin
					want = pending_writes.pop_front();
					if (want.addr != dst.dest_address || want.nib != dst.nibble_value ||
							want.upper != dst.upper_half || want.last != dst.last_of_run) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("%0t: addr exp %h got %h, nib exp %h got %h, ", $realtime,
								want.addr, dst.dest_address, want.nib, dst.nibble_value);
							$display("upper exp %b got %b, last exp %b got %b",
								want.upper, dst.upper_half, want.last, dst.last_of_run);
						end
					end
				end
			end
			if (cfg.valid && cfg.ready)
				apply_reg(cfg.index, cfg.data);
			if (src.valid && src.ready)
				blit_byte(src.mask_byte, src.image_start);
			writes_due = pending_writes.size();
		end
	end

endmodule

@@ dv/mask_2x_to_packed_nibble_blit_tb.sv @@
// Testbench top for the mask blitter: stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps

module mask_2x_to_packed_nibble_blit_tb;

	localparam int HOLD_CYCLES = 200;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   writes_due;
	bit   gaps_on;
	bit   stalls_on;
	bit   hold_out;

	m2xblit_in_if  src_ch();
	m2xblit_out_if dst_ch();
	m2xblit_cfg_if cfg_ch();

	mask_2x_to_packed_nibble_blit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_ch),
		.dst    (dst_ch),
		.cfg    (cfg_ch)
	);

	m2xblit_nibble_checker nibble_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src_ch),
		.dst        (dst_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.writes_due (writes_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Hold valid across back-to-back register writes; drop it after the last one.
	task automatic write_reg(input logic [m2xblit_pkg::CFG_IDX_W-1:0] idx, input int val,
			input bit last);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val[m2xblit_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		if (last)
			cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_geometry(input int dw, input int dh, input int sh, input int px,
			input int py);
		write_reg(m2xblit_pkg::REG_DEST_WIDTH, dw, 1'b0);
		write_reg(m2xblit_pkg::REG_DEST_HEIGHT, dh, 1'b0);
		write_reg(m2xblit_pkg::REG_SRC_HEIGHT, sh, 1'b0);
		write_reg(m2xblit_pkg::REG_POS_X, px, 1'b0);
		write_reg(m2xblit_pkg::REG_POS_Y, py, 1'b1);
	endtask

	task automatic set_config(input int dw, input int dh, input int sw, input int sh,
			input int px, input int py);
		write_reg(m2xblit_pkg::REG_SRC_WIDTH, sw, 1'b0);
		set_geometry(dw, dh, sh, px, py);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic first);
		int gap;
		gap = gaps_on ? int'($urandom_range(0, 3)) : 0;
		if (gap > 0) begin
			src_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_ch.valid       <= 1'b1;
		src_ch.mask_byte   <= b;
		src_ch.image_start <= first;
		do @(posedge clk); while (!src_ch.ready);
	endtask

	// Drain all expected words, then give the pipe time to empty.
	task automatic settle();
		src_ch.valid <= 1'b0;
		@(posedge clk);
		while (writes_due != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		dst_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			if (hold_out) begin
				dst_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end
			stall = stalls_on ? int'($urandom_range(0, 3)) : 0;
			if (stall > 0) begin
				dst_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dst_ch.ready <= 1'b1;
			do @(posedge clk); while (!dst_ch.valid);
		end
	end

	initial begin
		int nbytes, kind, phase;
		bit resume;
		arst_n             <= 1'b0;
		src_ch.valid       <= 1'b0;
		src_ch.mask_byte   <= '0;
		src_ch.image_start <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= '0;
		cfg_ch.data        <= '0;
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		hold_out  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain picture, odd trailing row, bytes past the last row, restart
		set_config(16, 8, 16, 5, 0, 0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h81, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h3C, 1'b1);
		settle();

		// negative position, odd source width, narrow destination
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		set_config(7, 2, 13, 6, -3, -1);
		for (int i = 0; i < 8; i++)
			send_byte(8'($urandom), i == 0);
		settle();

		// saturated destination, highest address and wrap past it
		set_config(8191, 8191, 8, 4, 4094, 4095);
		for (int i = 0; i < 4; i++)
			send_byte(8'($urandom), i == 0);
		settle();

		// empty source, then a source too narrow for any column
		set_config(0, 0, 0, 4, -4096, -4096);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		settle();
		write_reg(m2xblit_pkg::REG_SRC_WIDTH, 1, 1'b1);
		send_byte(8'hC3, 1'b1);
		send_byte(8'h3C, 1'b0);
		settle();

		// shrink the pitch under the current column
		set_config(64, 16, 64, 8, 0, 0);
		for (int i = 0; i < 3; i++)
			send_byte(8'($urandom), i == 0);
		settle();
		write_reg(m2xblit_pkg::REG_SRC_WIDTH, 8, 1'b1);
		for (int i = 0; i < 3; i++)
			send_byte(8'($urandom), 1'b0);
		settle();

		// saturated source width: a full even row, then the odd row wraps in
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		set_config(4096, 4, 4095, 2, 0, 0);
		for (int i = 0; i < 262; i++)
			send_byte(8'($urandom), i == 0);
		settle();

		phase = 0;
		while (phase < 6) begin
			kind      = int'($urandom_range(0, 9));
			gaps_on   = $urandom_range(0, 2) != 0;
			stalls_on = $urandom_range(0, 2) != 0;
			resume    = 1'b0;
			nbytes    = int'($urandom_range(2, 6));
			if (phase == 2) begin
				// hold the receiver off while the sender keeps pushing
				gaps_on = 1'b0;
				set_config(64, 16, 32, 8, 0, 0);
				hold_out = 1'b1;
				nbytes   = 24;
			end else if (kind == 0) begin
				// keep the source width and carry on with the current picture
				set_geometry(int'($urandom_range(1, 64)), int'($urandom_range(1, 16)),
					int'($urandom_range(2, 10)), int'($urandom_range(0, 24)) - 8,
					int'($urandom_range(0, 8)) - 4);
				resume = 1'b1;
			end else if (kind <= 6) begin
				set_config(int'($urandom_range(1, 64)), int'($urandom_range(1, 16)),
					int'($urandom_range(2, 48)), int'($urandom_range(2, 10)),
					int'($urandom_range(0, 24)) - 8, int'($urandom_range(0, 8)) - 4);
			end else begin
				set_config(int'($urandom_range(0, 8191)), int'($urandom_range(0, 8191)),
					int'($urandom_range(0, 4095)), int'($urandom_range(0, 8191)),
					int'($urandom_range(0, 8192)) - 4096,
					int'($urandom_range(0, 8192)) - 4096);
			end
			for (int i = 0; i < nbytes; i++)
				send_byte(8'($urandom), (i == 0 && !resume) ||
					(phase != 2 && $urandom_range(0, 31) == 0));
			settle();
			phase++;
		end

		if (writes_due != 0)
			$display("%0d nibble writes never arrived", writes_due);
		if (mismatches == 0 && writes_due == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
